// ===== rtl/core/ccd_pkg.sv =====
package ccd_pkg;

  typedef enum logic [2:0] {
    ROLE_MAGIC   = 3'd0,
    ROLE_SIZE    = 3'd1,
    ROLE_RES     = 3'd2,
    ROLE_NAME    = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_TRAIL   = 3'd5
  } role_t;

  localparam int PREAMBLE_LEN = 32;
  localparam int NAME_START   = 16;
  localparam int HOLD_LEN     = 8;
  localparam int MAGIC_LEN    = 4;

  localparam logic [7:0] MAGIC_0 = 8'h43;
  localparam logic [7:0] MAGIC_1 = 8'h41;
  localparam logic [7:0] MAGIC_2 = 8'h50;
  localparam logic [7:0] MAGIC_3 = 8'h52;

  // one queued job: a single tagged byte, or the eight held preamble bytes
  typedef struct packed {
    logic        burst;
    role_t       role;
    logic [63:0] data;
    logic [63:0] offset;
    logic [31:0] count;
    logic [31:0] plen;
    logic        chunk_end;
    logic        dirty;
  } qent_t;

endpackage

// ===== rtl/core/ccd_front.sv =====
module ccd_front #(
  parameter int OFFSET_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [47:0]   file_size,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          start_of_file,
  output logic          push,
  output ccd_pkg::qent_t push_ent,
  input  logic          full
);
  import ccd_pkg::*;

  logic [OFFSET_BITS-1:0] stream_offset, stream_offset_next;
  logic [OFFSET_BITS-1:0] chunk_base, chunk_base_next;
  logic [4:0]  pos, pos_next;
  logic        in_payload, in_payload_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] size_shift, size_shift_next;
  logic [31:0] chunks_done, chunks_done_next;
  logic        name_term, name_term_next;
  logic        name_dirty, name_dirty_next;
  logic        trailing, trailing_next;
  logic [7:0]  held [HOLD_LEN];

  logic [OFFSET_BITS-1:0] e_off, e_cb;
  logic [4:0]  e_pos;
  logic        e_inpay, e_nt, e_nd, e_trail;
  logic [31:0] e_left, e_size, e_cnt;
  logic        check, trail, accept, hold_we, finish, ok, magic_ok;
  logic [64:0] room;
  logic [31:0] size, left_dec;
  logic        nt2, nd2;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // a new archive clears the parse state before its first byte is taken
    e_off   = start_of_file ? '0 : stream_offset;
    e_cb    = start_of_file ? '0 : chunk_base;
    e_pos   = start_of_file ? '0 : pos;
    e_inpay = start_of_file ? 1'b0 : in_payload;
    e_left  = start_of_file ? '0 : payload_left;
    e_size  = start_of_file ? '0 : size_shift;
    e_cnt   = start_of_file ? '0 : chunks_done;
    e_nt    = start_of_file ? 1'b0 : name_term;
    e_nd    = start_of_file ? 1'b0 : name_dirty;
    e_trail = start_of_file ? 1'b0 : trailing;

    room     = {1'b0, 16'd0, file_size} - {1'b0, 64'(e_cb)};
    size     = {held[4], held[5], held[6], in_byte};
    magic_ok = held[0] == MAGIC_0 && held[1] == MAGIC_1 &&
               held[2] == MAGIC_2 && held[3] == MAGIC_3;
    ok       = magic_ok && !room[64] &&
               room[63:0] >= 64'(size) + 64'(PREAMBLE_LEN);
    check    = !e_trail && !e_inpay && e_pos == '0;
    trail    = e_trail || (check && (room[64] || room[63:0] < 64'(PREAMBLE_LEN)));
    left_dec = e_left - 32'd1;
    nt2      = e_nt || in_byte == 8'd0;
    nd2      = e_nd || (e_nt && in_byte != 8'd0);

    stream_offset_next = e_off + OFFSET_BITS'(1);
    chunk_base_next    = e_cb;
    pos_next           = e_pos;
    in_payload_next    = e_inpay;
    payload_left_next  = e_left;
    size_shift_next    = e_size;
    chunks_done_next   = e_cnt;
    name_term_next     = check ? 1'b0 : e_nt;
    name_dirty_next    = check ? 1'b0 : e_nd;
    trailing_next      = e_trail;
    hold_we            = 1'b0;
    finish             = 1'b0;
    push               = 1'b0;

    push_ent.burst     = 1'b0;
    push_ent.role      = ROLE_TRAIL;
    push_ent.data      = {56'd0, in_byte};
    push_ent.offset    = 64'(e_off);
    push_ent.count     = e_cnt;
    push_ent.plen      = '0;
    push_ent.chunk_end = 1'b0;
    push_ent.dirty     = 1'b0;

    if (trail) begin
      push          = 1'b1;
      trailing_next = 1'b1;
    end else if (e_inpay) begin
      push               = 1'b1;
      push_ent.role      = ROLE_PAYLOAD;
      push_ent.plen      = e_size;
      push_ent.chunk_end = left_dec == '0;
      payload_left_next  = left_dec;
      finish             = left_dec == '0;
    end else if (e_pos < 5'(HOLD_LEN)) begin
      hold_we = 1'b1;
      if (e_pos != 5'(HOLD_LEN - 1)) begin
        pos_next = e_pos + 5'd1;
      end else begin
        push            = 1'b1;
        push_ent.burst  = 1'b1;
        push_ent.data   = {in_byte, held[6], held[5], held[4],
                           held[3], held[2], held[1], held[0]};
        push_ent.offset = 64'(e_cb);
        if (ok) begin
          push_ent.role   = ROLE_MAGIC;
          push_ent.plen   = size;
          size_shift_next = size;
          pos_next        = 5'(HOLD_LEN);
        end else begin
          trailing_next = 1'b1;
        end
      end
    end else if (e_pos < 5'(NAME_START)) begin
      push          = 1'b1;
      push_ent.role = ROLE_RES;
      push_ent.plen = e_size;
      pos_next      = e_pos + 5'd1;
    end else begin
      push            = 1'b1;
      push_ent.role   = ROLE_NAME;
      name_term_next  = nt2;
      name_dirty_next = nd2;
      if (e_pos != 5'(PREAMBLE_LEN - 1)) begin
        push_ent.plen = e_size;
        pos_next      = e_pos + 5'd1;
      end else begin
        push_ent.dirty = nd2;
        if (e_size == '0) begin
          // empty payload: the name byte closes the chunk
          push_ent.chunk_end = 1'b1;
          finish             = 1'b1;
        end else begin
          push_ent.plen     = e_size;
          in_payload_next   = 1'b1;
          payload_left_next = e_size;
          pos_next          = '0;
        end
      end
    end

    if (finish) begin
      chunks_done_next  = (&e_cnt) ? e_cnt : e_cnt + 32'd1;
      chunk_base_next   = stream_offset_next;
      pos_next          = '0;
      in_payload_next   = 1'b0;
      payload_left_next = '0;
      name_term_next    = 1'b0;
      name_dirty_next   = 1'b0;
    end

    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_offset <= '0;
      chunk_base    <= '0;
      pos           <= '0;
      in_payload    <= 1'b0;
      payload_left  <= '0;
      size_shift    <= '0;
      chunks_done   <= '0;
      name_term     <= 1'b0;
      name_dirty    <= 1'b0;
      trailing      <= 1'b0;
    end else if (accept) begin
      stream_offset <= stream_offset_next;
      chunk_base    <= chunk_base_next;
      pos           <= pos_next;
      in_payload    <= in_payload_next;
      payload_left  <= payload_left_next;
      size_shift    <= size_shift_next;
      chunks_done   <= chunks_done_next;
      name_term     <= name_term_next;
      name_dirty    <= name_dirty_next;
      trailing      <= trailing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held[e_pos[2:0]] <= in_byte;
    end
  end

endmodule

// ===== rtl/core/ccd_fifo.sv =====
module ccd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccd_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output ccd_pkg::qent_t head,
  output logic           empty
);
  import ccd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

endmodule

// ===== rtl/core/ccd_back.sv =====
module ccd_back #(
  parameter int OFFSET_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  ccd_pkg::qent_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output ccd_pkg::role_t role,
  output logic [47:0]    byte_offset,
  output logic [31:0]    chunk_number,
  output logic [31:0]    payload_length,
  output logic           chunk_end,
  output logic           name_tail_dirty,
  output logic           last
);
  import ccd_pkg::*;

  logic [2:0]             idx;
  logic                   load, take, burst_last;
  logic [OFFSET_BITS-1:0] off_sum;
  logic [63:0]            off_ext;
  role_t                  role_sel;

  assign load       = !out_valid || out_ready;
  assign take       = load && !empty;
  assign burst_last = idx == 3'(HOLD_LEN - 1);
  assign pop        = take && (!head.burst || burst_last);

  always_comb begin
    off_sum = head.offset[OFFSET_BITS-1:0] + OFFSET_BITS'(idx);
    off_ext = 64'(off_sum);
    if (head.burst && head.role != ROLE_TRAIL) begin
      role_sel = (idx < 3'(MAGIC_LEN)) ? ROLE_MAGIC : ROLE_SIZE;
    end else begin
      role_sel = head.role;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        idx <= pop ? '0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte        <= head.burst ? head.data[idx*8 +: 8] : head.data[7:0];
      role            <= role_sel;
      byte_offset     <= off_ext[47:0];
      chunk_number    <= head.count;
      payload_length  <= head.plen;
      chunk_end       <= head.chunk_end;
      name_tail_dirty <= head.dirty;
      last            <= !head.burst || burst_last;
    end
  end

endmodule

// ===== rtl/core/chunk_container_deframer_top.sv =====
// channel  | dir | tdata                                       | tuser                 | tlast
// s_axis   | in  | [7:0] in_byte                               | [0] start_of_file     | -
// m_axis   | out | [7:0] out_byte, [55:8] byte_offset,         | [2:0] role,           | last
//          |     | [87:56] chunk_number, [119:88] payload_len  | [3] chunk_end,        |
//          |     |                                             | [4] name_tail_dirty   |
// apb      | in  | file_size at byte address 0 (64-bit data, low 48 bits used)
//
// one input byte per cycle; the front parser handles each byte in the cycle it is taken
// the eighth preamble byte of a chunk releases eight results, which the output stage
// sends one per cycle while m_tready is high, so input stalls only when the job queue is full
// each result is registered first in the job queue, then in the output register
// reset is synchronous and clears the parser, queue and output valid; no clearing pass
module chunk_container_deframer_top #(
  parameter int OFFSET_BITS = 48,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] in_byte
  input  logic          s_tuser,   // [0] start_of_file
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,   // out_byte, byte_offset, chunk_number, payload_length
  output logic [4:0]    m_tuser,   // role, chunk_end, name_tail_dirty
  output logic          m_tlast,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import ccd_pkg::*;

  localparam logic [2:0] ADDR_FILE_SIZE = 3'd0;

  logic [47:0] file_size;
  logic        push, pop, full, empty;
  qent_t       push_ent, head;

  logic [7:0]  out_byte;
  role_t       role;
  logic [47:0] byte_offset;
  logic [31:0] chunk_number, payload_length;
  logic        chunk_end, name_tail_dirty;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FILE_SIZE) ? {16'd0, file_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_FILE_SIZE) begin
      file_size <= pwdata[47:0];
    end
  end

  ccd_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .file_size     (file_size),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata),
    .start_of_file (s_tuser),
    .push          (push),
    .push_ent      (push_ent),
    .full          (full)
  );

  ccd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  ccd_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte        (out_byte),
    .role            (role),
    .byte_offset     (byte_offset),
    .chunk_number    (chunk_number),
    .payload_length  (payload_length),
    .chunk_end       (chunk_end),
    .name_tail_dirty (name_tail_dirty),
    .last            (m_tlast)
  );

  assign m_tdata = {payload_length, chunk_number, byte_offset, out_byte};
  assign m_tuser = {name_tail_dirty, chunk_end, role};

endmodule

// ===== rtl/core/ccd_checker.sv =====
module ccd_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic [4:0]   m_tuser,
  input logic         m_tlast
);
  import ccd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // trailing bytes carry no length and no flags
  a_trail_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] == ROLE_TRAIL |->
      m_tdata[119:88] == 32'd0 && !m_tuser[3] && !m_tuser[4])
    else $error("trailing result with length or flags");

  // a chunk ends only on a payload or name byte, which is a single result
  a_end_role: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |->
      m_tlast && (m_tuser[2:0] == ROLE_PAYLOAD || m_tuser[2:0] == ROLE_NAME))
    else $error("chunk end on wrong role");

  // the dirty flag appears only on a name byte
  a_dirty_role: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> m_tuser[2:0] == ROLE_NAME && m_tlast)
    else $error("name tail flag on wrong role");

  // burst bytes come without last, and offsets advance by one within the burst
  a_burst_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[55:8] == $past(m_tdata[55:8]) + 48'd1)
    else $error("burst offsets out of step");

endmodule

bind chunk_container_deframer_top ccd_checker u_ccd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
